// ===== rtl/core/bkt_pkg.sv =====
`default_nettype none

package bkt_pkg;

	localparam int DUR_W       = 48;
	localparam int TOL_W       = 16;
	localparam int CNT_W       = 8;
	localparam int PROD_W      = DUR_W + TOL_W;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 64;
	localparam int FIFO_DEPTH  = 8;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;
	localparam logic [CNT_W-1:0] MAX_RESET = 8'd20;
	localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;

	// Configuration register indexes.
	localparam logic CFG_TOLERANCE   = 1'b0;
	localparam logic CFG_MAX_SAMPLES = 1'b1;

	// Snapshot of the kept list that the convergence check needs.
	typedef struct packed {
		logic [DUR_W-1:0] best;
		logic [DUR_W-1:0] kth;
		logic [CNT_W-1:0] count;
	} track_t;

	// Result item, first field in the highest bits.
	typedef struct packed {
		logic [CNT_W-1:0] samples_taken;
		logic             finished;
		logic             converged;
		logic [DUR_W-1:0] best_duration;
	} result_t;

	localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== rtl/core/best_k_duration_tracker.sv =====
// Best-K duration tracker.
// Each item on the s_ channel carries one measured duration and a restart
// flag; each produces exactly one item on the m_ channel with the smallest
// kept duration, the converged and finished flags and the sample count.
// The KEEP_BEST smallest nonzero durations are held in a sorted register
// list that is updated by parallel compares and a shift. An item passes
// the input register, the list and the result registers to the queue.
// Throughput is one item per cycle while s_tready is high.
// Results wait in an eight-entry output queue; s_tready drops only when
// the queue plus the items still in the pipeline would fill it, so a
// stalled receiver holds its data and never loses a result.
// Reset clears the list and the count and loads the tolerance (655, about
// one percent) and max_samples (20). Configuration writes through cfg_we,
// cfg_index and cfg_wdata take effect at once and are meant for idle times.
`default_nettype none

module best_k_duration_tracker #(
	parameter int KEEP_BEST = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [47:0] sample_duration
	input  wire logic [bkt_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] restart
	input  wire logic                           s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [47:0] best_duration, [48] converged, [49] finished,
	// [57:50] samples_taken, [63:58] zero
	output logic [bkt_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [bkt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bkt_pkg::*;

	localparam int FCW = $clog2(FIFO_DEPTH + 1);

	logic [TOL_W-1:0] tol_q;
	logic [CNT_W-1:0] max_q;

	logic             valid_s1;
	logic [DUR_W-1:0] sample_s1;
	logic             restart_s1;
	logic             valid_s2;
	logic             take;

	track_t           track;
	logic             push;
	result_t          res;
	result_t          head;
	logic [FCW-1:0]   fifo_cnt;
	logic [FCW-1:0]   pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOLERANCE:   tol_q <= cfg_wdata[TOL_W-1:0];
				CFG_MAX_SAMPLES: max_q <= cfg_wdata[CNT_W-1:0];
				default:         ;
			endcase
		end
	end

	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1  <= s_tdata[DUR_W-1:0];
			restart_s1 <= s_tuser;
		end
	end

	bkt_list #(
		.KEEP_BEST (KEEP_BEST)
	) u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (valid_s1),
		.sample  (sample_s1),
		.restart (restart_s1),
		.track   (track)
	);

	bkt_conv #(
		.KEEP_BEST (KEEP_BEST)
	) u_conv (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (valid_s2),
		.track         (track),
		.tolerance_q16 (tol_q),
		.max_samples   (max_q),
		.push          (push),
		.res           (res)
	);

	bkt_fifo #(
		.WIDTH (RES_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.pop       (m_tready),
		.out_valid (m_tvalid),
		.out_data  (head),
		.count     (fifo_cnt)
	);

	// Items in the pipeline already own a queue slot.
	assign pending  = fifo_cnt + FCW'(valid_s1) + FCW'(valid_s2) + FCW'(push);
	assign s_tready = pending < FCW'(FIFO_DEPTH);
	assign m_tdata  = {(OUT_DATA_W - RES_W)'(0), head};

endmodule

`default_nettype wire

// ===== rtl/core/bkt_list.sv =====
`default_nettype none

module bkt_list #(
	parameter int KEEP_BEST = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      take,
	input  wire logic [bkt_pkg::DUR_W-1:0] sample,
	input  wire logic                      restart,
	output bkt_pkg::track_t                track
);
	import bkt_pkg::*;

	logic [DUR_W-1:0] list_q [KEEP_BEST];
	logic [CNT_W-1:0] cnt_q;

	logic [DUR_W-1:0] base [KEEP_BEST];
	logic [DUR_W-1:0] nxt  [KEEP_BEST];
	logic [CNT_W-1:0] base_cnt;
	logic [CNT_W-1:0] nxt_cnt;
	logic [CNT_W-1:0] slot;
	logic [KEEP_BEST-1:0] gt;
	logic             full;
	logic             nonzero;
	logic             ins;

	always_comb begin
		for (int i = 0; i < KEEP_BEST; i++) begin
			base[i] = restart ? '0 : list_q[i];
		end
		base_cnt = restart ? '0 : cnt_q;
		full     = base_cnt >= CNT_W'(KEEP_BEST);
		slot     = full ? CNT_W'(KEEP_BEST - 1) : base_cnt;
		nonzero  = sample != '0;
		ins      = nonzero && (!full || sample < base[KEEP_BEST-1]);
		nxt_cnt  = (nonzero && base_cnt != CNT_MAX) ? base_cnt + 1'b1 : base_cnt;
	end

	// Every slot compares against the sample at once; the insertion point is
	// the first slot holding a larger value, and everything after it moves up.
	for (genvar i = 0; i < KEEP_BEST; i++) begin : g_slot
		assign gt[i] = (CNT_W'(i) >= slot) || (base[i] > sample);
		if (i == 0) begin : g_head
			assign nxt[i] = (ins && gt[i]) ? sample : base[i];
		end else begin : g_body
			always_comb begin
				if (ins && CNT_W'(i) <= slot) begin
					nxt[i] = gt[i-1] ? base[i-1] : (gt[i] ? sample : base[i]);
				end else begin
					nxt[i] = base[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEEP_BEST; i++) begin
				list_q[i] <= '0;
			end
			cnt_q <= '0;
		end else if (take) begin
			for (int i = 0; i < KEEP_BEST; i++) begin
				list_q[i] <= nxt[i];
			end
			cnt_q <= nxt_cnt;
		end
	end

	assign track.best  = list_q[0];
	assign track.kth   = list_q[KEEP_BEST-1];
	assign track.count = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/bkt_conv.sv =====
`default_nettype none

module bkt_conv #(
	parameter int KEEP_BEST = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire bkt_pkg::track_t           track,
	input  wire logic [bkt_pkg::TOL_W-1:0] tolerance_q16,
	input  wire logic [bkt_pkg::CNT_W-1:0] max_samples,
	output logic                           push,
	output bkt_pkg::result_t               res
);
	import bkt_pkg::*;

	logic              valid_s3;
	logic [DUR_W-1:0]  best_s3;
	logic [DUR_W-1:0]  diff_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [CNT_W-1:0]  cnt_s3;
	logic              full_s3;
	logic              le_s3;
	logic              conv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= en;
		end
	end

	// The product and the spread are registered before they are compared.
	always_ff @(posedge clk) begin
		if (en) begin
			best_s3 <= track.best;
			diff_s3 <= track.kth - track.best;
			prod_s3 <= PROD_W'(track.best) * PROD_W'(tolerance_q16);
			cnt_s3  <= track.count;
			full_s3 <= track.count >= CNT_W'(KEEP_BEST);
			le_s3   <= track.kth <= track.best;
		end
	end

	assign conv = full_s3 && (le_s3 || {diff_s3, TOL_W'(0)} <= prod_s3);

	assign push              = valid_s3;
	assign res.best_duration = best_s3;
	assign res.converged     = conv;
	assign res.finished      = conv || cnt_s3 >= max_samples;
	assign res.samples_taken = cnt_s3;

endmodule

`default_nettype wire

// ===== rtl/core/bkt_fifo.sv =====
`default_nettype none

module bkt_fifo #(
	parameter int WIDTH = 58,
	parameter int DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	input  wire logic                       pop,
	output logic                            out_valid,
	output logic [WIDTH-1:0]                out_data,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0]           mem_q [DEPTH];
	logic [PW-1:0]              wr_q;
	logic [PW-1:0]              rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic                       do_pop;

	assign do_pop = pop && cnt_q != '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign count     = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/bkt_checker.sv =====
`default_nettype none

module bkt_checker #(
	parameter int KEEP_BEST = 5
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result item changed while stalled");

	a_conv_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[49])
		else $error("converged without finished");

	a_conv_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[57:50] >= 8'(KEEP_BEST))
		else $error("converged before the list was full");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[57:50] == 8'd0) == (m_tdata[47:0] == 48'd0))
		else $error("best duration and sample count disagree on empty list");

endmodule

bind best_k_duration_tracker bkt_checker #(
	.KEEP_BEST (KEEP_BEST)
) u_bkt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
